// ===== rtl/kmsd_pkg.sv =====
// Package for the key matrix scan decoder: queue entry type, matrix bit
// positions and the three fixed code tables. No dependencies.
package kmsd_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int MATRIX_W    = 64;
   localparam int SHIFT_A_BIT = 15;
   localparam int SHIFT_B_BIT = 52;
   localparam int CTRL_BIT    = 58;
   localparam int SPECIAL_BIT = 61;

   localparam logic [MATRIX_W-1:0] MOD_MASK =
      (64'd1 << SHIFT_A_BIT) | (64'd1 << SHIFT_B_BIT) | (64'd1 << CTRL_BIT);

   // classified item handed from the front to the back
   typedef struct packed {
      logic [7:0] code;
      logic       has_key;
      logic       special_down;
      logic       peek;
   } entry_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } queue_status_type;

   localparam logic [7:0] PLAIN_TBL [64] = '{
      8'h18, 8'h0A, 8'h1D, 8'h88, 8'h85, 8'h86, 8'h87, 8'h11,
      8'h33, 8'h77, 8'h61, 8'h34, 8'h7A, 8'h73, 8'h65, 8'h00,
      8'h35, 8'h72, 8'h64, 8'h36, 8'h63, 8'h66, 8'h74, 8'h78,
      8'h37, 8'h79, 8'h67, 8'h38, 8'h62, 8'h68, 8'h75, 8'h76,
      8'h39, 8'h69, 8'h6A, 8'h30, 8'h6D, 8'h6B, 8'h6F, 8'h6E,
      8'h2B, 8'h70, 8'h6C, 8'h2D, 8'h2E, 8'h3A, 8'h40, 8'h2C,
      8'h5F, 8'h2A, 8'h3B, 8'h13, 8'h00, 8'h3D, 8'h5E, 8'h2F,
      8'h31, 8'h5F, 8'h04, 8'h32, 8'h20, 8'h00, 8'h71, 8'h03
   };

   localparam logic [7:0] SHIFT_TBL [64] = '{
      8'h18, 8'h0A, 8'h9D, 8'h8C, 8'h89, 8'h8A, 8'h8B, 8'h91,
      8'h23, 8'h57, 8'h41, 8'h24, 8'h5A, 8'h53, 8'h45, 8'h00,
      8'h25, 8'h52, 8'h44, 8'h26, 8'h43, 8'h46, 8'h54, 8'h58,
      8'h2F, 8'h59, 8'h47, 8'h28, 8'h42, 8'h48, 8'h55, 8'h56,
      8'h29, 8'h49, 8'h4A, 8'h30, 8'h4D, 8'h4B, 8'h4F, 8'h4E,
      8'h2B, 8'h50, 8'h4C, 8'h2D, 8'h3E, 8'h5B, 8'h40, 8'h3C,
      8'h2D, 8'h2A, 8'h5D, 8'h93, 8'h00, 8'h3D, 8'hDE, 8'h3F,
      8'h21, 8'h5F, 8'h04, 8'h22, 8'h20, 8'h00, 8'h51, 8'h83
   };

   localparam logic [7:0] CTRL_TBL [64] = '{
      8'h0C, 8'h0A, 8'h9D, 8'h8C, 8'h89, 8'h8A, 8'h8B, 8'h91,
      8'h23, 8'h57, 8'h41, 8'h24, 8'h5A, 8'h53, 8'h45, 8'h00,
      8'h25, 8'h52, 8'h44, 8'h26, 8'h05, 8'h46, 8'h54, 8'h58,
      8'h2F, 8'h59, 8'h47, 8'h28, 8'h42, 8'h48, 8'h55, 8'h56,
      8'h29, 8'h49, 8'h4A, 8'h30, 8'h4D, 8'h4B, 8'h4F, 8'h4E,
      8'h2B, 8'h50, 8'h4C, 8'h2D, 8'h2E, 8'h5B, 8'h40, 8'h2C,
      8'h2D, 8'h2A, 8'h5D, 8'h93, 8'h00, 8'h3D, 8'hDE, 8'h3F,
      8'h21, 8'h5F, 8'h04, 8'h22, 8'h20, 8'h00, 8'h51, 8'h83
   };

   // shift wins over ctrl
   function automatic logic [7:0] lookup_code(input logic [5:0] idx, input logic shift,
                                              input logic ctrl);
      logic [7:0] code;
      if (shift) begin
         code = SHIFT_TBL[idx];
      end else if (ctrl) begin
         code = CTRL_TBL[idx];
      end else begin
         code = PLAIN_TBL[idx];
      end
      return code;
   endfunction

endpackage

// ===== rtl/kmsd_front.sv =====
// Front end of the key matrix scan decoder: modifier decode, priority
// encoding of the lowest pressed key and table lookup. Uses kmsd_pkg.
module kmsd_front (
   input  logic [63:0]         req_matrix_lines,
   input  logic                req_peek,
   output kmsd_pkg::entry_type entry
);

   logic [63:0] pressed;
   logic [63:0] scan;
   logic        shift;
   logic        ctrl;
   logic [7:0]  grp_any;
   logic [2:0]  grp_sel;
   logic [7:0]  grp_bits;
   logic [2:0]  bit_sel;

   assign pressed = ~req_matrix_lines;
   assign shift   = pressed[kmsd_pkg::SHIFT_A_BIT] | pressed[kmsd_pkg::SHIFT_B_BIT];
   assign ctrl    = pressed[kmsd_pkg::CTRL_BIT];
   assign scan    = pressed & ~kmsd_pkg::MOD_MASK;

   // two-level priority encode: lowest busy row group, then lowest bit in it
   always_comb begin
      for (int g = 0; g < 8; g++) begin
         grp_any[g] = |scan[8*g +: 8];
      end
      grp_sel = 3'd0;
      for (int g = 7; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_sel = 3'(g);
         end
      end
      grp_bits = scan[8*grp_sel +: 8];
      bit_sel  = 3'd0;
      for (int b = 7; b >= 0; b--) begin
         if (grp_bits[b]) begin
            bit_sel = 3'(b);
         end
      end
   end

   always_comb begin
      entry.has_key      = |grp_any;
      entry.code         = entry.has_key ? kmsd_pkg::lookup_code({grp_sel, bit_sel}, shift, ctrl)
                                         : 8'h00;
      entry.special_down = pressed[kmsd_pkg::SPECIAL_BIT];
      entry.peek         = req_peek;
   end

endmodule

// ===== rtl/kmsd_queue.sv =====
// Short queue between front and back of the key matrix scan decoder.
// Uses kmsd_pkg for the entry type and depth.
module kmsd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  kmsd_pkg::entry_type        push_entry,
   input  logic                       pop,
   output kmsd_pkg::entry_type        head_entry,
   output kmsd_pkg::queue_status_type status
);

   kmsd_pkg::entry_type             mem_ff [kmsd_pkg::QUEUE_DEPTH];
   logic [kmsd_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [kmsd_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [kmsd_pkg::QCNT_W-1:0]     count_ff, count_in;

   function automatic logic [kmsd_pkg::QPTR_W-1:0] next_ptr(
      input logic [kmsd_pkg::QPTR_W-1:0] ptr);
      logic [kmsd_pkg::QPTR_W-1:0] nxt;
      if (ptr == kmsd_pkg::QPTR_W'(kmsd_pkg::QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + kmsd_pkg::QPTR_W'(1);
      end
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + kmsd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - kmsd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == kmsd_pkg::QCNT_W'(kmsd_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/kmsd_back.sv =====
// Back end of the key matrix scan decoder: repeat suppression, special key
// edge detect and the result register. Uses kmsd_pkg for the entry type.
module kmsd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  kmsd_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_key_code,
   output logic                rsp_special_edge
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] key_code_ff, key_code_in;
   logic       special_edge_ff, special_edge_in;
   logic [7:0] last_code_ff, last_code_in;
   logic       special_held_ff, special_held_in;

   // take the head whenever the result slot is free or draining
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      key_code_in     = key_code_ff;
      special_edge_in = special_edge_ff;
      last_code_in    = last_code_ff;
      special_held_in = special_held_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (head_entry.has_key) begin
            if (head_entry.peek) begin
               key_code_in = head_entry.code;
            end else if (head_entry.code != last_code_ff) begin
               key_code_in  = head_entry.code;
               last_code_in = head_entry.code;
            end else begin
               key_code_in = 8'h00;
            end
         end else begin
            key_code_in = 8'h00;
            if (!head_entry.peek) begin
               last_code_in = 8'h00;
            end
         end
         special_edge_in = head_entry.special_down && !special_held_ff;
         special_held_in = head_entry.special_down;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         last_code_ff    <= 8'h00;
         special_held_ff <= 1'b0;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         last_code_ff    <= last_code_in;
         special_held_ff <= special_held_in;
      end
   end

   always_ff @(posedge clock) begin
      key_code_ff     <= key_code_in;
      special_edge_ff <= special_edge_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_code     = key_code_ff;
   assign rsp_special_edge = special_edge_ff;

endmodule

// ===== rtl/key_matrix_scan_decoder_core.sv =====
// Key matrix scan decoder top level: front classifier, two-entry queue and back end.
// Path: an accepted item is written into the queue, then into the result register
// when the result slot is free or draining. Throughput: one item per cycle while the
// result is not stalled; under a result stall the queue fills with two items and
// then stalls the input. Depends on kmsd_pkg and the kmsd_* modules.
// Reset (synchronous, active high) empties queue and result, clears repeat memory.
module key_matrix_scan_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_matrix_lines,
   input  logic        req_peek,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_key_code,
   output logic        rsp_special_edge
);

   kmsd_pkg::entry_type        front_entry;
   kmsd_pkg::entry_type        head_entry;
   kmsd_pkg::queue_status_type q_status;
   logic                       push;
   logic                       pop;

   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall;

   kmsd_front u_front (
      .req_matrix_lines (req_matrix_lines),
      .req_peek         (req_peek),
      .entry            (front_entry)
   );

   kmsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   kmsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (!q_status.empty),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_code     (rsp_key_code),
      .rsp_special_edge (rsp_special_edge)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= kmsd_pkg::QCNT_W'(kmsd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("back end popped an empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (q_status.count == $past(q_status.count) + kmsd_pkg::QCNT_W'(1)))
      else $error("queue count missed a push");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && q_status.empty))
      else $error("result or queue not empty after reset");

endmodule
